/* rtl/tlvt_pkg.sv */
// Shared types and constants for the timestamp visit table.
package tlvt_pkg;

	localparam int TABLE_DEPTH_DEFAULT = 64;
	localparam int KeyW  = 32;
	localparam int TimeW = 32;
	localparam int SlotW = 6;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_MARK   = 1'b1;

	typedef struct packed {
		logic             command;
		logic [KeyW-1:0]  key_id;
		logic [TimeW-1:0] now;
	} tlvt_req_t;

	typedef struct packed {
		logic             found;
		logic [TimeW-1:0] stamp;
		logic [SlotW-1:0] slot;
		logic             replaced;
	} tlvt_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} tlvt_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} tlvt_ctl_t;

	typedef struct packed {
		logic match;
		logic drained;
	} tlvt_sts_t;

endpackage

/* rtl/tlvt_ctrl.sv */
// Sequencer for the timestamp visit table: idle, scan and commit phases.
module tlvt_ctrl import tlvt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  tlvt_sts_t sts,
	output tlvt_ctl_t ctl,
	output logic      busy
);

	tlvt_state_t state_q;
	tlvt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.match || sts.drained) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		ctl.load   = 1'b0;
		ctl.scan   = 1'b0;
		ctl.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

/* rtl/tlvt_dp.sv */
// Datapath of the timestamp visit table: entry memories, scan pipeline and result register.
module tlvt_dp import tlvt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tlvt_req_t req,
	input  tlvt_ctl_t ctl,
	output tlvt_sts_t sts,
	output tlvt_rsp_t rsp,
	output logic      done
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

	logic [KeyW-1:0]  key_mem  [TABLE_DEPTH];
	logic [TimeW-1:0] time_mem [TABLE_DEPTH];

	tlvt_req_t        req_q;
	logic [UW-1:0]    used_q;
	logic [UW-1:0]    cnt_q;
	logic             vld_s1;
	logic [IW-1:0]    idx_s1;
	logic [KeyW-1:0]  key_s1;
	logic [TimeW-1:0] time_s1;
	logic [TimeW:0]   best_q;
	logic [IW-1:0]    victim_q;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic [TimeW-1:0] hit_time_q;
	tlvt_rsp_t        rsp_q;
	logic             done_q;

	logic             issue;
	logic             match;
	logic             older;
	logic             wr_en;
	logic             append;
	logic [IW-1:0]    wr_idx;
	logic [IW-1:0]    slot_idx;
	logic [IW+SlotW-1:0] slot_ext;
	tlvt_rsp_t        rsp_d;

	assign issue = ctl.scan && (cnt_q < used_q);
	assign match = ctl.scan && vld_s1 && (key_s1 == req_q.key_id);
	assign older = ctl.scan && vld_s1 && !match && ({1'b0, time_s1} < best_q);

	assign sts.match   = match;
	assign sts.drained = (cnt_q >= used_q) && !vld_s1;

	// Decide the write-back and the result of the finished scan.
	always_comb begin
		wr_en    = 1'b0;
		append   = 1'b0;
		wr_idx   = hit_idx_q;
		slot_idx = '0;
		rsp_d    = '0;
		if (hit_q) begin
			wr_en       = (req_q.command == CMD_MARK);
			slot_idx    = hit_idx_q;
			rsp_d.found = 1'b1;
			rsp_d.stamp = (req_q.command == CMD_MARK) ? req_q.now : hit_time_q;
		end else if (req_q.command == CMD_MARK) begin
			wr_en       = 1'b1;
			rsp_d.stamp = req_q.now;
			if (used_q < DEPTH_U) begin
				append = 1'b1;
				wr_idx = used_q[IW-1:0];
			end else begin
				wr_idx         = victim_q;
				rsp_d.replaced = 1'b1;
			end
			slot_idx = wr_idx;
		end
		slot_ext   = {{SlotW{1'b0}}, slot_idx};
		rsp_d.slot = slot_ext[SlotW-1:0];
		wr_en      = wr_en && ctl.commit;
		append     = append && ctl.commit;
	end

	// Entry memories: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx]  <= req_q.key_id;
			time_mem[wr_idx] <= req_q.now;
		end
		key_s1  <= key_mem[cnt_q[IW-1:0]];
		time_s1 <= time_mem[cnt_q[IW-1:0]];
		idx_s1  <= cnt_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			done_q <= ctl.commit;
			if (ctl.load) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (match) begin
				hit_q <= 1'b1;
			end
			if (append) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q    <= req;
			best_q   <= {1'b0, req.now} + 1'b1;
			victim_q <= '0;
		end else if (older) begin
			best_q   <= {1'b0, time_s1};
			victim_q <= idx_s1;
		end
		if (match) begin
			hit_idx_q  <= idx_s1;
			hit_time_q <= time_s1;
		end
		if (ctl.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

/* rtl/timestamp_lru_visit_table.sv */
// Top level of the timestamp visit table with least-recent replacement.
//
// A command is transferred at a rising edge where start is high and busy is low.
// The req struct carries the command (lookup or mark), the key and the current tick.
// Exactly one result follows each command: done is high for one cycle and rsp
// holds found, stamp, slot and replaced during that cycle. The receiver cannot
// stall, so the result is transferred at the edge that ends the done cycle.
// After the command transfer the block scans the used entries, one per cycle,
// through the registered read port of the entry memories. The scan stops early
// on a key match. The commit cycle then writes the entry back and registers the
// result, and done rises in the next cycle together with busy falling. The next
// command may be transferred at the edge that ends the done cycle.
// Reset clears the fill count and the controller; entry contents are not
// cleared, as only entries below the fill count are ever read, so no clearing
// pass is needed and the block accepts commands right after reset.
module timestamp_lru_visit_table import tlvt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  tlvt_req_t req,
	output logic      done,
	output tlvt_rsp_t rsp
);

	// Command and status between the sequencer and the datapath.
	tlvt_ctl_t ctl;
	tlvt_sts_t sts;

	tlvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	tlvt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

/* rtl/tlvt_chk.sv */
// Port-level checker for the timestamp visit table, bound to the top level.
module tlvt_chk import tlvt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input tlvt_rsp_t rsp
);

	// A transferred command keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer not followed by busy");

	// The result shows exactly when the block leaves the busy phase.
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result without a preceding busy phase");

	// Results never come in consecutive cycles, since each takes a scan and commit.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// An eviction only happens on a miss.
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.found && rsp.replaced))
		else $error("hit reported with an eviction");

endmodule

bind timestamp_lru_visit_table tlvt_chk u_tlvt_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
